/* sv/lbps_pkg.sv */
// ============================================================================
// LED breathing PWM sequencer package
// Shared constants, codes and the command/status types that join the
// controller and the datapath.
// ============================================================================
package lbps_pkg;

    localparam int unsigned DEF_SINE_TABLE_DEPTH = 1024;
    localparam int unsigned DEF_DUTY_MAX         = 4095;

    localparam int unsigned NOW_W      = 32;
    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned PHASE_W    = 32;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned MODE_W     = 3;

    localparam int unsigned FADE_STEP    = 50;
    localparam int unsigned RESET_PERIOD = 100;

    localparam logic [PHASE_W:0]   PHASE_FULL       = {1'b1, {PHASE_W{1'b0}}};
    localparam logic [PHASE_W-1:0] RESET_PHASE_STEP = PHASE_W'(PHASE_FULL / RESET_PERIOD);

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_SET_LEVEL  = 2'd1,
        OP_START_SINE = 2'd2,
        OP_START_FADE = 2'd3
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF       = 3'd0,
        MODE_ON        = 3'd1,
        MODE_FADE_UP   = 3'd2,
        MODE_FADE_DOWN = 3'd3,
        MODE_SINE      = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_SINE_ADDR,
        ST_SINE_DUTY,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_start;
        logic sine_set;
        logic sine_phase;
        logic sine_addr;
        logic sine_duty;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic mode_sine;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

/* sv/led_breathing_pwm_sequencer.sv */
// ============================================================================
// LED breathing PWM sequencer
// Off / on / triangle fade / sine duty sequencer producing one result per
// request on a stream interface, with a fade interval register.
// ============================================================================
// Usage:
//   Requests enter on the s_ group: s_tuser carries the operation (tick update,
//   set level, start sine, start fade), s_tdata the tick count, level and sine
//   period. Every request yields exactly one result on the m_ group: duty and
//   mode in m_tdata, the write flag in m_tuser.
//   The fade interval is written on the cfg_ channel, which is always ready;
//   write it only while no request is in progress.
//   From acceptance to m_tvalid, a tick in off, on or fade mode and set
//   level / start fade pass through the decode and output states; a sine
//   tick adds the phase update, table fold and registered table read; start
//   sine waits for the 33-step radix-2 divider that forms the phase step.
//   One request is worked at a time; s_tready returns the cycle after the
//   result is loaded into the output register, so a new request can be taken
//   also while a result still waits on m_tready.
//   A stalled receiver holds the output register and the controller waits
//   with the next finished result.
//   Reset: mode off, level 0, phase 0, phase step 2^32/100, interval 0.
// ============================================================================
module led_breathing_pwm_sequencer
#(
    parameter int unsigned SINE_TABLE_DEPTH = lbps_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int unsigned DUTY_MAX         = lbps_pkg::DEF_DUTY_MAX
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // now_ticks, duty_value, sine_period, zero pad
    input  logic [((lbps_pkg::NOW_W + $clog2(DUTY_MAX+1) + lbps_pkg::PERIOD_W + 7) / 8) * 8 - 1:0]
                                                    s_tdata,
    // operation
    input  logic [lbps_pkg::OP_W-1:0]               s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // pwm_duty, mode_now, zero pad
    output logic [(($clog2(DUTY_MAX+1) + lbps_pkg::MODE_W + 7) / 8) * 8 - 1:0]
                                                    m_tdata,
    // pwm_written
    output logic [0:0]                              m_tuser,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [lbps_pkg::INTERVAL_W-1:0]         cfg_data
);

    localparam int unsigned DUTY_W      = $clog2(DUTY_MAX + 1);
    localparam int unsigned NOW_W       = lbps_pkg::NOW_W;
    localparam int unsigned PERIOD_W    = lbps_pkg::PERIOD_W;
    localparam int unsigned OUT_W       = DUTY_W + lbps_pkg::MODE_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    lbps_pkg::cmd_t         cmd;
    lbps_pkg::status_t      status;
    logic [DUTY_W-1:0]      out_duty;
    logic                   out_written;
    lbps_pkg::mode_t        out_mode;

    assign cfg_ready = 1'b1;

    lbps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lbps_datapath
    #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .DUTY_MAX         (DUTY_MAX)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .in_op       (lbps_pkg::op_t'(s_tuser)),
        .in_now      (s_tdata[NOW_W-1:0]),
        .in_duty     (s_tdata[NOW_W+DUTY_W-1:NOW_W]),
        .in_period   (s_tdata[NOW_W+DUTY_W+PERIOD_W-1:NOW_W+DUTY_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_duty    (out_duty),
        .out_written (out_written),
        .out_mode    (out_mode)
    );

    assign m_tdata = OUT_TDATA_W'({out_mode, out_duty});
    assign m_tuser = out_written;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[DUTY_W-1:0] == '0)
        else $error("duty nonzero on a result without a write");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:DUTY_W] <= lbps_pkg::MODE_W'(lbps_pkg::MODE_SINE))
        else $error("result mode out of range");

    a_div_for_sine: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> status.op == lbps_pkg::OP_START_SINE)
        else $error("divider finished outside a start sine request");

endmodule

/* sv/lbps_div.sv */
// ============================================================================
// Phase step divider
// Restoring radix-2 divider that forms floor(2^32 / divisor), one quotient
// bit per cycle, saturated to 32 bits.
// ============================================================================
module lbps_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [lbps_pkg::PERIOD_W-1:0]       divisor,
    output logic                                done,
    output logic [lbps_pkg::PHASE_W-1:0]        quotient
);

    localparam int unsigned NUM_W = lbps_pkg::PHASE_W + 1;
    localparam int unsigned REM_W = lbps_pkg::PERIOD_W + 1;
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]               num_reg, num_next;
    logic [NUM_W-1:0]               quo_reg, quo_next;
    logic [REM_W-1:0]               rem_reg, rem_next;
    logic [lbps_pkg::PERIOD_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [REM_W-1:0]               trial;

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
        if (start)
        begin
            num_next  = lbps_pkg::PHASE_FULL;
            quo_next  = '0;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[NUM_W-1] ? '1 : quo_reg[NUM_W-2:0];

endmodule

/* sv/lbps_sine_rom.sv */
// ============================================================================
// Quarter-wave sine table
// Constant table of floor(H*sin) magnitudes with an inexact flag for the
// first quadrant, built at elaboration in Q62 fixed point; registered read.
// ============================================================================
module lbps_sine_rom
#(
    parameter int unsigned SINE_TABLE_DEPTH = lbps_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int unsigned DUTY_MAX         = lbps_pkg::DEF_DUTY_MAX
)
(
    input  logic                                        clk,
    input  logic                                        rd_en,
    input  logic [$clog2(SINE_TABLE_DEPTH/4)-1:0]       rd_addr,
    output logic [$clog2(DUTY_MAX+1):0]                 rd_data
);

    localparam int unsigned DUTY_W  = $clog2(DUTY_MAX + 1);
    localparam int unsigned QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int unsigned HALF    = DUTY_MAX / 2;
    localparam logic [63:0] Q_STEP  = lbps_pkg::HALF_PI_Q62 / SINE_TABLE_DEPTH;
    localparam logic [63:0] R_STEP  = lbps_pkg::HALF_PI_Q62 % SINE_TABLE_DEPTH;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] sine_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        x2   = mul_q62(x, x);
        term = x;
        pos  = x;
        neg  = '0;
        for (int n = 1; n <= 12; n++)
        begin
            term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0)
                neg = neg + term;
            else
                pos = pos + term;
        end
        return pos - neg;
    endfunction

    function automatic logic [DUTY_W:0] rom_entry(input int unsigned k);
        logic [63:0]  a;
        logic [63:0]  x;
        logic [63:0]  s;
        logic [127:0] p;
        a = 64'(4 * k);
        x = Q_STEP * a + (R_STEP * a) / SINE_TABLE_DEPTH;
        if (k == 0)
            s = '0;
        else
            s = sine_q62(x);
        p = {64'b0, s} * 128'(HALF);
        return {p[61:0] != 62'b0, p[62+DUTY_W-1:62]};
    endfunction

    logic [DUTY_W:0] table_w [QUARTER];
    logic [DUTY_W:0] data_reg;

    for (genvar g = 0; g < QUARTER; g++)
    begin : g_table
        localparam logic [DUTY_W:0] ENTRY = rom_entry(g);
        assign table_w[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            data_reg <= table_w[rd_addr];
    end

    assign rd_data = data_reg;

endmodule

/* sv/lbps_datapath.sv */
// ============================================================================
// LED breathing PWM datapath
// Request capture, mode/level/timing state, fade and sine updates, phase
// step divider, sine table fold and the output register.
// ============================================================================
module lbps_datapath
#(
    parameter int unsigned SINE_TABLE_DEPTH = lbps_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int unsigned DUTY_MAX         = lbps_pkg::DEF_DUTY_MAX
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  lbps_pkg::cmd_t                          cmd,
    output lbps_pkg::status_t                       status,
    input  logic                                    cfg_we,
    input  logic [lbps_pkg::INTERVAL_W-1:0]         cfg_data,
    input  lbps_pkg::op_t                           in_op,
    input  logic [lbps_pkg::NOW_W-1:0]              in_now,
    input  logic [$clog2(DUTY_MAX+1)-1:0]           in_duty,
    input  logic [lbps_pkg::PERIOD_W-1:0]           in_period,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [$clog2(DUTY_MAX+1)-1:0]           out_duty,
    output logic                                    out_written,
    output lbps_pkg::mode_t                         out_mode
);

    localparam int unsigned DUTY_W  = $clog2(DUTY_MAX + 1);
    localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int unsigned QA_W    = $clog2(QUARTER);
    localparam int unsigned FW      = IDX_W + 1;
    localparam int unsigned PROD_W  = lbps_pkg::PHASE_W + IDX_W + 1;
    localparam int unsigned NOW_W   = lbps_pkg::NOW_W;
    localparam int unsigned PHASE_W = lbps_pkg::PHASE_W;
    localparam logic [DUTY_W-1:0] DUTY_TOP  = DUTY_W'(DUTY_MAX);
    localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_W'(DUTY_MAX / 2);
    localparam logic [DUTY_W-1:0] STEP      = DUTY_W'(lbps_pkg::FADE_STEP);

    lbps_pkg::op_t                      op_reg;
    logic [NOW_W-1:0]                   now_reg;
    logic [DUTY_W-1:0]                  dv_reg;
    logic [lbps_pkg::PERIOD_W-1:0]      per_reg;

    lbps_pkg::mode_t                    mode_reg, mode_next;
    logic [DUTY_W-1:0]                  level_reg, level_next;
    logic [NOW_W-1:0]                   last_reg, last_next;
    logic [PHASE_W-1:0]                 phase_reg, phase_next;
    logic [PHASE_W-1:0]                 step_reg, step_next;
    logic [lbps_pkg::INTERVAL_W-1:0]    interval_reg;

    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic                               neg_reg, neg_next;
    logic                               top_reg, top_next;
    logic [DUTY_W-1:0]                  res_duty_reg, res_duty_next;
    logic                               res_wr_reg, res_wr_next;

    logic                               out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]                  out_duty_reg;
    logic                               out_wr_reg;
    lbps_pkg::mode_t                    out_mode_reg;

    logic                               div_done;
    logic [PHASE_W-1:0]                 div_quotient;
    logic [lbps_pkg::PERIOD_W-1:0]      divisor;

    logic [QA_W-1:0]                    rom_addr;
    logic [DUTY_W:0]                    rom_data;

    logic [NOW_W-1:0]                   elapsed;
    logic [NOW_W-1:0]                   interval_ext;
    logic [DUTY_W:0]                    up_sum;
    logic [PHASE_W:0]                   phase_sum;
    logic [PHASE_W-1:0]                 phase_new;
    logic [PROD_W-1:0]                  idx_prod;
    logic [FW-1:0]                      fold_i;
    logic [FW-1:0]                      fold_k;
    logic                               fold_neg;
    logic [DUTY_W-1:0]                  mag;
    logic [DUTY_W-1:0]                  inexact;

    assign divisor = (per_reg == '0) ? lbps_pkg::PERIOD_W'(1) : per_reg;

    lbps_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    lbps_sine_rom
    #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .DUTY_MAX         (DUTY_MAX)
    )
    u_rom
    (
        .clk     (clk),
        .rd_en   (cmd.sine_addr),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    assign elapsed      = now_reg - last_reg;
    assign interval_ext = NOW_W'(interval_reg);
    assign up_sum       = {1'b0, level_reg} + {1'b0, STEP};
    assign phase_sum    = {1'b0, phase_reg} + {1'b0, step_reg};
    assign phase_new    = phase_sum[PHASE_W] ? '0 : phase_sum[PHASE_W-1:0];
    assign idx_prod     = PROD_W'(phase_new) * PROD_W'(SINE_TABLE_DEPTH);

    always_comb
    begin
        fold_i = {1'b0, idx_reg};
        if (fold_i <= FW'(QUARTER))
        begin
            fold_k   = fold_i;
            fold_neg = 1'b0;
        end
        else if (fold_i <= FW'(2 * QUARTER))
        begin
            fold_k   = FW'(2 * QUARTER) - fold_i;
            fold_neg = 1'b0;
        end
        else if (fold_i <= FW'(3 * QUARTER))
        begin
            fold_k   = fold_i - FW'(2 * QUARTER);
            fold_neg = 1'b1;
        end
        else
        begin
            fold_k   = FW'(4 * QUARTER) - fold_i;
            fold_neg = 1'b1;
        end
    end

    assign top_next = (fold_k == FW'(QUARTER));
    assign neg_next = fold_neg;
    assign rom_addr = top_next ? '0 : fold_k[QA_W-1:0];
    assign idx_next = idx_prod[PHASE_W+IDX_W-1:PHASE_W];

    assign mag     = top_reg ? DUTY_HALF : rom_data[DUTY_W-1:0];
    assign inexact = top_reg ? '0 : DUTY_W'(rom_data[DUTY_W]);

    always_comb
    begin
        mode_next     = mode_reg;
        level_next    = level_reg;
        last_next     = last_reg;
        phase_next    = phase_reg;
        step_next     = step_reg;
        res_duty_next = res_duty_reg;
        res_wr_next   = res_wr_reg;
        if (cmd.exec)
        begin
            res_duty_next = '0;
            res_wr_next   = 1'b0;
            unique case (op_reg)
                lbps_pkg::OP_SET_LEVEL:
                begin
                    mode_next  = lbps_pkg::MODE_ON;
                    level_next = (dv_reg > DUTY_TOP) ? DUTY_TOP : dv_reg;
                end
                lbps_pkg::OP_START_FADE:
                begin
                    mode_next = lbps_pkg::MODE_FADE_UP;
                    last_next = now_reg;
                end
                lbps_pkg::OP_START_SINE:
                begin
                    mode_next = mode_reg;
                end
                lbps_pkg::OP_TICK:
                begin
                    case (mode_reg)
                        lbps_pkg::MODE_OFF:
                        begin
                            res_wr_next = 1'b1;
                        end
                        lbps_pkg::MODE_ON:
                        begin
                            res_duty_next = level_reg;
                            res_wr_next   = 1'b1;
                        end
                        lbps_pkg::MODE_FADE_UP:
                        begin
                            if (elapsed >= interval_ext)
                            begin
                                if (up_sum >= {1'b0, DUTY_TOP})
                                begin
                                    level_next    = DUTY_TOP;
                                    mode_next     = lbps_pkg::MODE_FADE_DOWN;
                                    res_duty_next = DUTY_TOP;
                                end
                                else
                                begin
                                    level_next    = up_sum[DUTY_W-1:0];
                                    res_duty_next = up_sum[DUTY_W-1:0];
                                end
                                res_wr_next = 1'b1;
                                last_next   = now_reg;
                            end
                        end
                        lbps_pkg::MODE_FADE_DOWN:
                        begin
                            if (elapsed > interval_ext)
                            begin
                                if (level_reg <= STEP)
                                begin
                                    level_next    = '0;
                                    mode_next     = lbps_pkg::MODE_FADE_UP;
                                    res_duty_next = '0;
                                end
                                else
                                begin
                                    level_next    = level_reg - STEP;
                                    res_duty_next = level_reg - STEP;
                                end
                                res_wr_next = 1'b1;
                                last_next   = now_reg;
                            end
                        end
                        default:
                        begin
                            res_wr_next = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    res_wr_next = 1'b0;
                end
            endcase
        end
        else if (cmd.sine_set)
        begin
            step_next     = div_quotient;
            mode_next     = lbps_pkg::MODE_SINE;
            last_next     = now_reg;
            res_duty_next = '0;
            res_wr_next   = 1'b0;
        end
        else if (cmd.sine_phase)
        begin
            phase_next = phase_new;
            last_next  = now_reg;
        end
        else if (cmd.sine_duty)
        begin
            res_duty_next = neg_reg ? (DUTY_HALF - mag - inexact) : (DUTY_HALF + mag);
            res_wr_next   = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lbps_pkg::MODE_OFF;
            level_reg     <= '0;
            last_reg      <= '0;
            phase_reg     <= '0;
            step_reg      <= lbps_pkg::RESET_PHASE_STEP;
            interval_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            level_reg     <= level_next;
            last_reg      <= last_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                interval_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            now_reg <= in_now;
            dv_reg  <= in_duty;
            per_reg <= in_period;
        end
        if (cmd.sine_phase)
            idx_reg <= idx_next;
        if (cmd.sine_addr)
        begin
            neg_reg <= neg_next;
            top_reg <= top_next;
        end
        res_duty_reg <= res_duty_next;
        res_wr_reg   <= res_wr_next;
        if (cmd.out_load)
        begin
            out_duty_reg <= res_duty_reg;
            out_wr_reg   <= res_wr_reg;
            out_mode_reg <= mode_reg;
        end
    end

    assign status.op        = op_reg;
    assign status.mode_sine = (mode_reg == lbps_pkg::MODE_SINE);
    assign status.div_done  = div_done;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_duty    = out_duty_reg;
    assign out_written = out_wr_reg;
    assign out_mode    = out_mode_reg;

endmodule

/* sv/lbps_ctrl.sv */
// ============================================================================
// LED breathing PWM controller
// Sequencing state machine: accept a request, run the update or command,
// wait for the divider or the sine table, then hand the result over.
// ============================================================================
module lbps_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lbps_pkg::status_t   status,
    output lbps_pkg::cmd_t      cmd
);

    lbps_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lbps_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            lbps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lbps_pkg::ST_DECODE;
                end
            end
            lbps_pkg::ST_DECODE:
            begin
                priority if (status.op == lbps_pkg::OP_START_SINE)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = lbps_pkg::ST_DIV;
                end
                else if (status.op == lbps_pkg::OP_TICK && status.mode_sine)
                begin
                    cmd.sine_phase = 1'b1;
                    state_next     = lbps_pkg::ST_SINE_ADDR;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = lbps_pkg::ST_OUTPUT;
                end
            end
            lbps_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.sine_set = 1'b1;
                    state_next   = lbps_pkg::ST_OUTPUT;
                end
            end
            lbps_pkg::ST_SINE_ADDR:
            begin
                cmd.sine_addr = 1'b1;
                state_next    = lbps_pkg::ST_SINE_DUTY;
            end
            lbps_pkg::ST_SINE_DUTY:
            begin
                cmd.sine_duty = 1'b1;
                state_next    = lbps_pkg::ST_OUTPUT;
            end
            lbps_pkg::ST_OUTPUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lbps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* verif/led_breathing_pwm_sequencer_tb.sv */
// ============================================================================
// LED breathing PWM sequencer testbench
// Drives tick updates and commands on the request stream and checks every
// result against a typed row's expectation or a cycle-free duty predictor
// with its own sine table. Directed rows cover the extremes, fade clamps
// and sine step saturation; random fade, sine and steady runs follow under
// several fade intervals, bursty requests and a stalling result receiver.
// ============================================================================
module led_breathing_pwm_sequencer_tb;
    import lbps_pkg::*;

    localparam int S_TDATA_W = ((NOW_W + 12 + PERIOD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((12 + MODE_W + 7) / 8) * 8;
    localparam bit [63:0] LUT_DEPTH = 64'(DEF_SINE_TABLE_DEPTH);
    localparam bit [63:0] LUT_HALF = 64'(DEF_DUTY_MAX / 2);
    localparam bit [12:0] DUTY_TOP = 13'(DEF_DUTY_MAX);
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 85;
    localparam int N_ROWS = 25;

    typedef struct packed {
        bit [11:0] duty;
        bit        written;
        mode_t     mode;
    } duty_result_t;

    typedef struct {
        op_t       op;
        bit [31:0] now;
        bit [11:0] level;
        bit [15:0] period;
        bit        typed;
        bit [11:0] want_duty;
        bit        want_written;
        mode_t     want_mode;
    } bench_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // now_ticks, duty_value, sine_period, zero pad
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // operation
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // pwm_duty, mode_now, zero pad
    logic [M_TDATA_W-1:0] m_tdata;
    // pwm_written
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [INTERVAL_W-1:0] cfg_data = '0;

    bit [11:0]    sine_lut [DEF_SINE_TABLE_DEPTH];
    mode_t        pred_mode = MODE_OFF;
    bit [12:0]    pred_level = '0;
    bit [31:0]    pred_mark = '0;
    bit [31:0]    pred_phase = '0;
    bit [31:0]    pred_step = RESET_PHASE_STEP;
    bit [15:0]    pred_interval = '0;

    duty_result_t pending_duty [$];
    int           error_count = 0;
    int           results_checked = 0;
    int           requests_sent = 0;
    int           burst_left = 0;
    bit [31:0]    tick_clock = '0;

    int           hold_asked = 0;
    int           hold_taken = 0;
    int           hold_count = 0;
    int           rx_style = 0;
    int           rx_span = 0;
    int           rx_stall = 0;

    bench_row_t directed_rows [N_ROWS] = '{
        '{OP_TICK,       32'd0,          12'd0,     16'd0,     1'b1, 12'd0,     1'b1, MODE_OFF},
        '{OP_TICK,       32'hFFFF_FFFF,  12'hFFF,   16'hFFFF,  1'b1, 12'd0,     1'b1, MODE_OFF},
        '{OP_SET_LEVEL,  32'd0,          12'hFFF,   16'd0,     1'b1, 12'd0,     1'b0, MODE_ON},
        '{OP_TICK,       32'd1,          12'd0,     16'd0,     1'b1, 12'hFFF,   1'b1, MODE_ON},
        '{OP_SET_LEVEL,  32'd2,          12'd0,     16'hFFFF,  1'b1, 12'd0,     1'b0, MODE_ON},
        '{OP_TICK,       32'd3,          12'hFFF,   16'd0,     1'b1, 12'd0,     1'b1, MODE_ON},
        '{OP_SET_LEVEL,  32'h5A5A_5A5A,  12'hA5A,   16'h5A5A,  1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_START_FADE, 32'd100,        12'd0,     16'd0,     1'b1, 12'd0,     1'b0, MODE_FADE_UP},
        '{OP_TICK,       32'd100,        12'd0,     16'd0,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_SET_LEVEL,  32'd150,        12'd4090,  16'd0,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_START_FADE, 32'd200,        12'd0,     16'd0,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_TICK,       32'd200,        12'd0,     16'd0,     1'b1, 12'hFFF,   1'b1, MODE_FADE_DOWN},
        '{OP_TICK,       32'd200,        12'd0,     16'd0,     1'b1, 12'd0,     1'b0, MODE_FADE_DOWN},
        '{OP_TICK,       32'd201,        12'd0,     16'd0,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_START_FADE, 32'hFFFF_FFF0,  12'd0,     16'd0,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_TICK,       32'd5,          12'd0,     16'd0,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_START_SINE, 32'd300,        12'd0,     16'd0,     1'b1, 12'd0,     1'b0, MODE_SINE},
        '{OP_TICK,       32'd301,        12'd0,     16'd0,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_TICK,       32'd302,        12'd0,     16'd0,     1'b1, 12'h7FF,   1'b1, MODE_SINE},
        '{OP_START_SINE, 32'd303,        12'd0,     16'd1,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_TICK,       32'd304,        12'd0,     16'd0,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_START_SINE, 32'd305,        12'd0,     16'hFFFF,  1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_TICK,       32'd306,        12'd0,     16'd0,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_START_SINE, 32'd307,        12'd0,     16'd4,     1'b0, 12'd0,     1'b0, MODE_OFF},
        '{OP_TICK,       32'd308,        12'd0,     16'd0,     1'b0, 12'd0,     1'b0, MODE_OFF}
    };

    bit [15:0] interval_plan [7] = '{16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd40, 16'd0, 16'd9};

    led_breathing_pwm_sequencer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit [63:0] q62_product(bit [63:0] a, bit [63:0] b, output bit dropped);
        bit [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        dropped = |p[61:0];
        return p[125:62];
    endfunction

    function automatic bit [63:0] q62_sine(bit [63:0] x);
        bit [63:0] x2;
        bit [63:0] term;
        bit [63:0] pos;
        bit [63:0] neg;
        bit        unused;
        x2 = q62_product(x, x, unused);
        term = x;
        pos = x;
        neg = '0;
        for (int n = 1; n <= 12; n++)
        begin
            term = q62_product(term, x2, unused) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        return pos - neg;
    endfunction

    task automatic build_sine_lut();
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] m;
        bit [63:0] a;
        bit [63:0] s;
        bit [63:0] mag;
        bit        below;
        bit        dropped;
        q = HALF_PI_Q62 / LUT_DEPTH;
        r = HALF_PI_Q62 % LUT_DEPTH;
        for (int i = 0; i < DEF_SINE_TABLE_DEPTH; i++)
        begin
            m = 64'(4 * i);
            if (m <= LUT_DEPTH)
            begin
                a = m;
                below = 1'b0;
            end
            else if (m <= 2 * LUT_DEPTH)
            begin
                a = 2 * LUT_DEPTH - m;
                below = 1'b0;
            end
            else if (m <= 3 * LUT_DEPTH)
            begin
                a = m - 2 * LUT_DEPTH;
                below = 1'b1;
            end
            else
            begin
                a = 4 * LUT_DEPTH - m;
                below = 1'b1;
            end
            if (a == 0)
                s = '0;
            else if (a == LUT_DEPTH)
                s = 64'd1 << 62;
            else
                s = q62_sine(q * a + (r * a) / LUT_DEPTH);
            mag = q62_product(s, LUT_HALF, dropped);
            if (below)
            begin
                mag += 64'(dropped);
                sine_lut[i] = 12'(LUT_HALF - mag);
            end
            else
            begin
                sine_lut[i] = 12'(LUT_HALF + mag);
            end
        end
    endtask

    function automatic duty_result_t compute_duty_update(op_t op, bit [31:0] now,
                                                         bit [11:0] level, bit [15:0] period);
        duty_result_t res;
        bit [31:0]    elapsed;
        bit [32:0]    sum;
        bit [32:0]    quotient;
        bit [16:0]    divisor;
        bit [63:0]    lut_pos;
        res = '0;
        case (op)
            OP_SET_LEVEL:
            begin
                pred_mode = MODE_ON;
                pred_level = ({1'b0, level} > DUTY_TOP) ? DUTY_TOP : {1'b0, level};
            end
            OP_START_SINE:
            begin
                divisor = (period == 16'd0) ? 17'd1 : {1'b0, period};
                quotient = 33'h1_0000_0000 / {16'd0, divisor};
                pred_step = quotient[32] ? 32'hFFFF_FFFF : quotient[31:0];
                pred_mode = MODE_SINE;
                pred_mark = now;
            end
            OP_START_FADE:
            begin
                pred_mode = MODE_FADE_UP;
                pred_mark = now;
            end
            default:
            begin
                elapsed = now - pred_mark;
                case (pred_mode)
                    MODE_OFF:
                        res.written = 1'b1;
                    MODE_ON:
                    begin
                        res.duty = pred_level[11:0];
                        res.written = 1'b1;
                    end
                    MODE_FADE_UP:
                        if (elapsed >= {16'd0, pred_interval})
                        begin
                            pred_level += 13'(FADE_STEP);
                            if (pred_level >= DUTY_TOP)
                            begin
                                pred_level = DUTY_TOP;
                                pred_mode = MODE_FADE_DOWN;
                            end
                            res.duty = pred_level[11:0];
                            res.written = 1'b1;
                            pred_mark = now;
                        end
                    MODE_FADE_DOWN:
                        if (elapsed > {16'd0, pred_interval})
                        begin
                            if (pred_level <= 13'(FADE_STEP))
                            begin
                                pred_level = '0;
                                pred_mode = MODE_FADE_UP;
                            end
                            else
                            begin
                                pred_level -= 13'(FADE_STEP);
                            end
                            res.duty = pred_level[11:0];
                            res.written = 1'b1;
                            pred_mark = now;
                        end
                    MODE_SINE:
                    begin
                        sum = {1'b0, pred_phase} + {1'b0, pred_step};
                        pred_phase = sum[32] ? 32'd0 : sum[31:0];
                        lut_pos = ({32'd0, pred_phase} * LUT_DEPTH) >> 32;
                        res.duty = sine_lut[int'(lut_pos)];
                        res.written = 1'b1;
                        pred_mark = now;
                    end
                    default:
                        ;
                endcase
            end
        endcase
        res.mode = pred_mode;
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, results_checked, got, want);
        error_count++;
    endtask

    task automatic check_result();
        duty_result_t want;
        if (pending_duty.size() == 0)
        begin
            report_mismatch("result with no request pending", m_tdata, 0);
        end
        else
        begin
            want = pending_duty.pop_front();
            if (m_tdata[11:0] !== want.duty)
                report_mismatch("pwm_duty", m_tdata[11:0], want.duty);
            if (m_tuser[0] !== want.written)
                report_mismatch("pwm_written", m_tuser[0], want.written);
            if (m_tdata[14:12] !== want.mode)
                report_mismatch("mode_now", m_tdata[14:12], want.mode);
        end
        results_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_taken != hold_asked)
        begin
            m_tready <= 1'b0;
            if (hold_count == HOLD_CYCLES - 1)
            begin
                hold_count <= 0;
                hold_taken <= hold_taken + 1;
            end
            else
            begin
                hold_count <= hold_count + 1;
            end
        end
        else
        begin
            if (rx_span == 0)
            begin
                rx_style <= $urandom_range(0, 2);
                rx_span <= $urandom_range(50, 400);
            end
            else
            begin
                rx_span <= rx_span - 1;
            end
            if (rx_stall != 0)
            begin
                m_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_style == 1 && $urandom_range(0, 3) == 0)
                    rx_stall <= $urandom_range(1, 3);
                else if (rx_style == 2 && $urandom_range(0, 1) == 0)
                    rx_stall <= $urandom_range(1, 12);
            end
        end
    end

    task automatic send_request(op_t op, bit [31:0] now, bit [11:0] level, bit [15:0] period,
                                bit typed = 1'b0, duty_result_t want = '0);
        duty_result_t predicted;
        int           gap;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'd0, period, level, now};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = compute_duty_update(op, now, level, period);
        pending_duty.push_back(typed ? want : predicted);
        requests_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 50) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_duty.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_interval(bit [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        pred_interval = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [31:0] advance_ticks(bit [15:0] iv);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            tick_clock = $urandom;
        else if (r < 3)
            tick_clock += {16'd0, iv};
        else if (r < 5)
            tick_clock += $urandom_range(0, iv);
        else
            tick_clock += {16'd0, iv} + 32'd1 + $urandom_range(0, iv / 4 + 2);
        return tick_clock;
    endfunction

    function automatic bit [11:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'hFFF;
            2:       return 12'($urandom_range(0, 60));
            3:       return 12'($urandom_range(4000, 4095));
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic bit [15:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4, 5: return 16'($urandom_range(2, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(int items, bit [15:0] iv);
        int stop;
        int kind;
        stop = requests_sent + items;
        tick_clock = $urandom;
        while (requests_sent < stop)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                if ($urandom_range(0, 1) == 1)
                    send_request(OP_SET_LEVEL, advance_ticks(iv), pick_level(), 16'($urandom));
                send_request(OP_START_FADE, advance_ticks(iv), 12'($urandom), 16'($urandom));
                repeat ($urandom_range(40, 200))
                    send_request(OP_TICK, advance_ticks(iv), 12'($urandom), 16'($urandom));
            end
            else if (kind < 6)
            begin
                send_request(OP_START_SINE, advance_ticks(iv), 12'($urandom), pick_period());
                repeat ($urandom_range(5, 60))
                    send_request(OP_TICK, advance_ticks(iv), 12'($urandom), 16'($urandom));
            end
            else if (kind < 8)
            begin
                send_request(OP_SET_LEVEL, advance_ticks(iv), pick_level(), 16'($urandom));
                repeat ($urandom_range(1, 8))
                    send_request(OP_TICK, advance_ticks(iv), 12'($urandom), 16'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                    send_request(op_t'($urandom_range(0, 3)), $urandom, 12'($urandom),
                                 16'($urandom));
            end
        end
    endtask

    initial
    begin
        bench_row_t   row;
        duty_result_t want;
        bit [15:0]    iv;
        build_sine_lut();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_ROWS; i++)
        begin
            row = directed_rows[i];
            want.duty = row.want_duty;
            want.written = row.want_written;
            want.mode = row.want_mode;
            send_request(row.op, row.now, row.level, row.period, row.typed, want);
        end
        for (int k = 0; k < 7; k++)
        begin
            wait_drain();
            repeat (4) @(posedge clk);
            iv = (k == 5) ? 16'($urandom) : interval_plan[k];
            write_interval(iv);
            run_phase(PHASE_ITEMS, iv);
            if (k == 0)
            begin
                hold_asked <= hold_asked + 1;
                repeat (16)
                    send_request(OP_TICK, advance_ticks(iv), 12'($urandom), 16'($urandom));
            end
        end
        wait_drain();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
